@@ hw/rtl/power_product_string_hash_macros.svh @@
// Assertion macros shared by the hash block.
`ifndef POWER_PRODUCT_STRING_HASH_MACROS_SVH
`define POWER_PRODUCT_STRING_HASH_MACROS_SVH

// Condition holds at every edge out of reset.
`define PPH_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PPH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define PPH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/pphash_pkg.sv @@
package pphash_pkg;

  localparam int unsigned MAX_LEN = 256;
  localparam int unsigned POS_W   = $clog2(MAX_LEN + 1);
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned BASE_W  = 32;
  localparam int unsigned HASH_W  = 64;
  localparam int unsigned HALF_W  = 32;
  localparam int unsigned STEP_W  = $clog2(BASE_W + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_LOOP,
    S_MUL_A,
    S_MUL_B,
    S_MUL_C,
    S_CHECK,
    S_MOD,
    S_FOLD_A,
    S_FOLD_B,
    S_FOLD_C,
    S_FOLD_SUM,
    S_END
  } state_t;

  typedef enum logic [1:0] {
    MP_NONE,
    MP_LL,
    MP_HL,
    MP_LH
  } mul_phase_t;

  typedef struct packed {
    logic       in_load;
    logic       setup;
    mul_phase_t mul_phase;
    logic       mul_fold;
    logic       acc_load;
    logic       k_inc;
    logic       mod_start;
    logic       rebase;
    logic       fold_update;
    logic       overflow_set;
    logic       out_load;
    logic       clear;
  } cmd_t;

  typedef struct packed {
    logic in_last;
    logic pos_full;
    logic k_done;
    logic k_zero;
    logic sum_zero;
    logic mod_done;
    logic out_free;
  } status_t;

endpackage

@@ hw/rtl/pphash_ctrl.sv @@
`include "power_product_string_hash_macros.svh"

module pphash_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pphash_pkg::status_t st,
  output pphash_pkg::cmd_t    cmd
);

  pphash_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pphash_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.mul_phase = pphash_pkg::MP_NONE;
    in_ready      = 1'b0;
    case (state)
      pphash_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_next  = pphash_pkg::S_SETUP;
        end
      end
      pphash_pkg::S_SETUP: begin
        if (st.pos_full) begin
          cmd.overflow_set = 1'b1;
          state_next       = pphash_pkg::S_END;
        end else begin
          cmd.setup  = 1'b1;
          state_next = pphash_pkg::S_LOOP;
        end
      end
      pphash_pkg::S_LOOP: begin
        state_next = st.k_done ? pphash_pkg::S_FOLD_A : pphash_pkg::S_MUL_A;
      end
      pphash_pkg::S_MUL_A: begin
        cmd.mul_phase = pphash_pkg::MP_LL;
        state_next    = pphash_pkg::S_MUL_B;
      end
      pphash_pkg::S_MUL_B: begin
        cmd.mul_phase = pphash_pkg::MP_HL;
        state_next    = pphash_pkg::S_MUL_C;
      end
      pphash_pkg::S_MUL_C: begin
        cmd.mul_phase = pphash_pkg::MP_LH;
        state_next    = pphash_pkg::S_CHECK;
      end
      pphash_pkg::S_CHECK: begin
        cmd.acc_load = 1'b1;
        if (!st.sum_zero) begin
          cmd.k_inc  = 1'b1;
          state_next = pphash_pkg::S_LOOP;
        end else if (st.k_zero) begin
          state_next = pphash_pkg::S_FOLD_A;
        end else begin
          cmd.mod_start = 1'b1;
          state_next    = pphash_pkg::S_MOD;
        end
      end
      pphash_pkg::S_MOD: begin
        if (st.mod_done) begin
          cmd.rebase = 1'b1;
          state_next = pphash_pkg::S_LOOP;
        end
      end
      pphash_pkg::S_FOLD_A: begin
        cmd.mul_fold  = 1'b1;
        cmd.mul_phase = pphash_pkg::MP_LL;
        state_next    = pphash_pkg::S_FOLD_B;
      end
      pphash_pkg::S_FOLD_B: begin
        cmd.mul_fold  = 1'b1;
        cmd.mul_phase = pphash_pkg::MP_HL;
        state_next    = pphash_pkg::S_FOLD_C;
      end
      pphash_pkg::S_FOLD_C: begin
        cmd.mul_fold  = 1'b1;
        cmd.mul_phase = pphash_pkg::MP_LH;
        state_next    = pphash_pkg::S_FOLD_SUM;
      end
      pphash_pkg::S_FOLD_SUM: begin
        cmd.fold_update = 1'b1;
        state_next      = pphash_pkg::S_END;
      end
      pphash_pkg::S_END: begin
        if (!st.in_last) begin
          state_next = pphash_pkg::S_IDLE;
        end else if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.clear    = 1'b1;
          state_next   = pphash_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pphash_pkg::S_IDLE;
      end
    endcase
  end

  `PPH_ASSERT_IMP(a_load_free, cmd.out_load, st.out_free, "result loaded over a pending one")
  `PPH_ASSERT_IMP(a_mod_divisor, cmd.mod_start, !st.k_zero, "reduction started with zero divisor")
  `PPH_ASSERT_NXT(a_accept_busy, in_valid && in_ready, state == pphash_pkg::S_SETUP,
                  "request taken without starting work")

endmodule

@@ hw/rtl/pphash_dp.sv @@
module pphash_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [pphash_pkg::BYTE_W-1:0]     byte_value,
  input  logic                              is_last,
  input  pphash_pkg::cmd_t                  cmd,
  output pphash_pkg::status_t               st,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pphash_pkg::HASH_W-1:0]     hash_value,
  output logic                              too_long
);

  localparam int unsigned POS_W  = pphash_pkg::POS_W;
  localparam int unsigned BASE_W = pphash_pkg::BASE_W;
  localparam int unsigned HASH_W = pphash_pkg::HASH_W;
  localparam int unsigned HALF_W = pphash_pkg::HALF_W;
  localparam int unsigned BYTE_W = pphash_pkg::BYTE_W;
  localparam int unsigned STEP_W = pphash_pkg::STEP_W;

  logic [HASH_W-1:0] product;
  logic [POS_W-1:0]  pos;
  logic              overflow;
  logic [BASE_W-1:0] base;
  logic              last;
  logic [POS_W-1:0]  count;
  logic [POS_W-1:0]  k;
  logic [HASH_W-1:0] acc;

  logic [HASH_W-1:0] r0;
  logic [HALF_W-1:0] r1;
  logic [HALF_W-1:0] r2;
  logic [HASH_W-1:0] op_a;
  logic [HASH_W-1:0] op_b;
  logic [HALF_W-1:0] mx;
  logic [HALF_W-1:0] my;
  logic [HASH_W-1:0] mprod;
  logic [HALF_W-1:0] mid_sum;
  logic [HASH_W-1:0] sum;

  logic              mod_busy;
  logic [STEP_W-1:0] mod_cnt;
  logic [BASE_W-1:0] mod_src;
  logic [POS_W-1:0]  rem;
  logic [POS_W:0]    rem_sh;
  logic [POS_W:0]    rem_diff;
  logic              rem_ge;

  assign op_a = cmd.mul_fold ? product : acc;
  assign op_b = cmd.mul_fold ? (acc + HASH_W'(1)) : HASH_W'(base);

  always_comb begin
    mx = op_a[HALF_W-1:0];
    my = op_b[HALF_W-1:0];
    case (cmd.mul_phase)
      pphash_pkg::MP_HL: begin
        mx = op_a[HASH_W-1:HALF_W];
      end
      pphash_pkg::MP_LH: begin
        my = op_b[HASH_W-1:HALF_W];
      end
      default: begin
      end
    endcase
  end

  assign mprod   = HASH_W'(mx) * HASH_W'(my);
  assign mid_sum = r1 + r2;
  assign sum     = r0 + {mid_sum, HALF_W'(0)};

  always_ff @(posedge clk) begin
    case (cmd.mul_phase)
      pphash_pkg::MP_LL: r0 <= mprod;
      pphash_pkg::MP_HL: r1 <= mprod[HALF_W-1:0];
      pphash_pkg::MP_LH: r2 <= mprod[HALF_W-1:0];
      default: begin
      end
    endcase
  end

  assign rem_sh   = {rem, mod_src[BASE_W-1]};
  assign rem_diff = rem_sh - {1'b0, k};
  assign rem_ge   = rem_sh >= {1'b0, k};

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_busy <= 1'b0;
    end else if (cmd.mod_start) begin
      mod_busy <= 1'b1;
    end else if (mod_busy && mod_cnt == '0) begin
      mod_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mod_start) begin
      mod_cnt <= STEP_W'(BASE_W);
      mod_src <= base;
      rem     <= '0;
    end else if (mod_busy && mod_cnt != '0) begin
      mod_cnt <= mod_cnt - STEP_W'(1);
      mod_src <= {mod_src[BASE_W-2:0], 1'b0};
      rem     <= rem_ge ? rem_diff[POS_W-1:0] : rem_sh[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      base  <= {{(BASE_W-BYTE_W){byte_value[BYTE_W-1]}}, byte_value};
      last  <= is_last;
      count <= pos + POS_W'(1);
    end else if (cmd.rebase) begin
      base  <= BASE_W'(rem) + BASE_W'(1);
      count <= count - POS_W'(1);
    end
    if (cmd.setup) begin
      acc <= HASH_W'(base);
      k   <= '0;
    end else if (cmd.rebase) begin
      acc <= HASH_W'(rem) + HASH_W'(1);
      k   <= '0;
    end else begin
      if (cmd.acc_load) begin
        acc <= sum;
      end
      if (cmd.k_inc) begin
        k <= k + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      product  <= HASH_W'(1);
      pos      <= '0;
      overflow <= 1'b0;
    end else begin
      if (cmd.fold_update) begin
        product <= sum;
        pos     <= pos + POS_W'(1);
      end
      if (cmd.overflow_set) begin
        overflow <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      hash_value <= product;
      too_long   <= overflow;
    end
  end

  assign st.in_last  = last;
  assign st.pos_full = pos >= POS_W'(pphash_pkg::MAX_LEN);
  assign st.k_done   = k == count;
  assign st.k_zero   = k == '0;
  assign st.sum_zero = sum == '0;
  assign st.mod_done = mod_busy && mod_cnt == '0;
  assign st.out_free = !out_valid || out_ready;

endmodule

@@ hw/rtl/power_product_string_hash.sv @@
// Channel   Direction  tdata                     tuser     tlast
// s_axis    in         [7:0] byte_value          -         is_last
// m_axis    out        [63:0] hash_value         too_long  -
//
// One byte at a time; the byte at position i goes through the shared 32x32 multiplier
// (three partial products per 64-bit multiply).
// A zero product with a nonzero index adds a bit-serial remainder and reruns
// the power from the reduced base.
// Reset (rst, synchronous) restores product 1, position 0, no overflow.
// A result stalled on m_axis holds the block in its last step of the next
// password until the pending result is taken.
module power_product_string_hash (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [pphash_pkg::BYTE_W-1:0]     s_axis_tdata,   // [7:0] byte_value
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [pphash_pkg::HASH_W-1:0]     m_axis_tdata,   // [63:0] hash_value
  output logic                              m_axis_tuser    // [0] too_long
);

  pphash_pkg::cmd_t    cmd;
  pphash_pkg::status_t st;

  pphash_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  pphash_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .byte_value (s_axis_tdata),
    .is_last    (s_axis_tlast),
    .cmd        (cmd),
    .st         (st),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .hash_value (m_axis_tdata),
    .too_long   (m_axis_tuser)
  );

endmodule
